[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the heading controller.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// the expression must never be true at a clock edge
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("assertion failed: forbidden condition seen");
// whenever ante holds, cons holds at the same edge
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication violated");
`else
`define ASSERT_NEVER(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/hps_pkg.sv]
// Shared types and constants of the heading controller.
// No dependencies; used by hps_mul, hps_div and heading_pid_steering.
package hps_pkg;

	// angle scaling: radians times 2^ANGLE_FRAC_BITS
	localparam int ANGLE_FRAC_BITS = 12;
	localparam int PI_Q = int'(((64'd205887 << ANGLE_FRAC_BITS) + 64'd32768) >> 16);
	localparam int TWO_PI_Q = 2 * PI_Q;

	// integral term is scaled by 1/1000 (ms to s)
	localparam int INTEG_SCALE = 1000;

	// shared shift-add multiplier
	localparam int MUL_A_W = 16;
	localparam int MUL_B_W = 32;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// shared restoring divider
	localparam int DIV_N_W = 48;
	localparam int DIV_D_W = 32;

	typedef enum logic [2:0] {
		REG_GOAL_HEADING  = 3'd0,
		REG_GAIN_PROP     = 3'd1,
		REG_GAIN_INTEG    = 3'd2,
		REG_GAIN_DERIV    = 3'd3,
		REG_TURN_LIMIT    = 3'd4,
		REG_DEAD_BAND     = 3'd5,
		REG_CRUISE_SPEED  = 3'd6,
		REG_UPDATE_PERIOD = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

[rtl/core/hps_mul.sv]
// Radix-2 shift-add multiplier: one multiplier bit per cycle, unsigned operands.
// Depends on hps_pkg for widths and the unit status struct.
module hps_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [hps_pkg::MUL_A_W-1:0]   mult_a,
	input  logic [hps_pkg::MUL_B_W-1:0]   mult_b,
	output hps_pkg::unit_stat_t           stat,
	output logic [hps_pkg::MUL_P_W-1:0]   product
);

	localparam int CNT_W = $clog2(hps_pkg::MUL_A_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [hps_pkg::MUL_B_W-1:0] hi_q;
	logic [hps_pkg::MUL_A_W-1:0] lo_q;
	logic [hps_pkg::MUL_B_W-1:0] b_q;
	logic [hps_pkg::MUL_B_W-1:0] addend;
	logic [hps_pkg::MUL_B_W:0]   sum;

	assign addend = lo_q[0] ? b_q : '0;
	assign sum = {1'b0, hi_q} + {1'b0, addend};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(hps_pkg::MUL_A_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift the partial product right, taking in one multiplier bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			hi_q <= '0;
			lo_q <= mult_a;
			b_q  <= mult_b;
		end else if (busy_q) begin
			hi_q <= sum[hps_pkg::MUL_B_W:1];
			lo_q <= {sum[0], lo_q[hps_pkg::MUL_A_W-1:1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign product   = {hi_q, lo_q};

endmodule

[rtl/core/hps_div.sv]
// Restoring divider: one quotient bit per cycle, unsigned operands, divisor nonzero.
// Depends on hps_pkg for widths and the unit status struct.
module hps_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [hps_pkg::DIV_N_W-1:0]   dividend,
	input  logic [hps_pkg::DIV_D_W-1:0]   divisor,
	output hps_pkg::unit_stat_t           stat,
	output logic [hps_pkg::DIV_N_W-1:0]   quotient
);

	localparam int CNT_W = $clog2(hps_pkg::DIV_N_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [hps_pkg::DIV_D_W-1:0] rem_q;
	logic [hps_pkg::DIV_N_W-1:0] quo_q;
	logic [hps_pkg::DIV_D_W-1:0] dvs_q;
	logic [hps_pkg::DIV_D_W:0]   trial;
	logic [hps_pkg::DIV_D_W:0]   diff;
	logic                        fits;

	assign trial = {rem_q, quo_q[hps_pkg::DIV_N_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(hps_pkg::DIV_N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend bits leave at the top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[hps_pkg::DIV_D_W-1:0] : trial[hps_pkg::DIV_D_W-1:0];
			quo_q <= {quo_q[hps_pkg::DIV_N_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

[rtl/core/heading_pid_steering.sv]
// Heading PID controller: one shared 16-step shift-add multiplier, one 48-step divider.
// An accepted item that comes too early is dropped, one inside the dead band yields a stop
// result, and a PID result takes four multiplies and two divides on the shared units; each
// result waits until the output register is free. One item at a time: the next is accepted
// in the cycle after the result loads the output register, or after a dropped item's check.
// arst_n clears control state, loads register defaults and zeroes the controller state.
`include "assert_macros.svh"

module heading_pid_steering (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,      // [31:0] time_now, [46:32] heading, [47] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,      // [15:0] forward_speed, [30:16] turn_rate, [31] zero
	output logic        m_tuser,      // [0] stopped
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_wr_index,
	input  logic [15:0] cfg_wr_data
);

	localparam int AFB   = hps_pkg::ANGLE_FRAC_BITS;
	localparam int SUM_W = 45;
	localparam int W_W   = SUM_W - AFB;
	localparam logic signed [16:0] TWO_PI_V = 17'(hps_pkg::TWO_PI_Q);
	localparam logic signed [16:0] PI_V     = 17'(hps_pkg::PI_Q);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_BAND,
		ST_MUL_E,
		ST_SUM_S,
		ST_MUL_I,
		ST_DIV_I,
		ST_MUL_D,
		ST_DIV_D,
		ST_MUL_P,
		ST_SUM_W,
		ST_CLAMP,
		ST_LIMIT,
		ST_EMIT
	} state_t;

	state_t state_q;

	// configuration
	logic [14:0] goal_heading_q;
	logic [15:0] gain_prop_q;
	logic [15:0] gain_integ_q;
	logic [15:0] gain_deriv_q;
	logic [13:0] turn_limit_q;
	logic [13:0] dead_band_q;
	logic [15:0] cruise_speed_q;
	logic [15:0] update_period_q;

	// controller state
	logic [31:0]        last_update_q;
	logic signed [31:0] integral_q;
	logic signed [15:0] prev_error_q;

	// work registers
	logic [31:0]              now_q;
	logic [31:0]              dt_q;
	logic signed [16:0]       diff_q;
	logic signed [14:0]       r_q;
	logic [25:0]              dd_q;
	logic                     dd_neg_q;
	logic signed [31:0]       s_q;
	logic signed [38:0]       i_q;
	logic signed [42:0]       d_q;
	logic signed [30:0]       p_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [W_W-1:0]    w_q;
	logic [15:0]              res_speed_q;
	logic [14:0]              res_turn_q;
	logic                     res_stop_q;

	// output register
	logic        m_tvalid_q;
	logic [15:0] out_speed_q;
	logic [14:0] out_turn_q;
	logic        out_stop_q;

	// arithmetic units
	logic                          mul_start_q;
	logic                          div_start_q;
	logic [hps_pkg::MUL_A_W-1:0]   mul_a;
	logic [hps_pkg::MUL_B_W-1:0]   mul_b;
	logic [hps_pkg::MUL_P_W-1:0]   mul_product;
	hps_pkg::unit_stat_t           mul_stat;
	logic [hps_pkg::DIV_D_W-1:0]   div_divisor;
	logic [hps_pkg::DIV_N_W-1:0]   div_quotient;
	hps_pkg::unit_stat_t           div_stat;

	// combinational helpers
	logic [15:0]             period;
	logic                    too_early;
	logic signed [16:0]      m1, m2, m3, m4;
	logic [14:0]             r_abs;
	logic                    in_band;
	logic signed [16:0]      rd_diff;
	logic [15:0]             rd_abs;
	logic [25:0]             dd_next;
	logic signed [48:0]      ed_mag;
	logic signed [48:0]      ed;
	logic signed [48:0]      s_sum;
	logic                    s_fits;
	logic signed [31:0]      s_sat;
	logic [31:0]             s_abs;
	logic signed [38:0]      i_mag;
	logic signed [42:0]      d_mag;
	logic signed [30:0]      p_mag;
	logic signed [SUM_W-1:0] w_bias;
	logic signed [SUM_W-1:0] w_biased;
	logic signed [W_W-1:0]   lim_pos;
	logic signed [W_W-1:0]   w_lim;
	logic                    mul_phase;
	logic                    units_busy;

	assign period    = (update_period_q == 16'd0) ? 16'd1 : update_period_q;
	assign too_early = (dt_q < {16'd0, period});

	// wrap goal minus heading into (-pi, pi]
	always_comb begin
		m1 = (diff_q < 0) ? diff_q + TWO_PI_V : diff_q;
		m2 = (m1 < 0) ? m1 + TWO_PI_V : m1;
		m3 = (m2 >= TWO_PI_V) ? m2 - TWO_PI_V : m2;
		m4 = (m3 > PI_V) ? m3 - TWO_PI_V : m3;
	end

	assign r_abs   = r_q[14] ? 15'(-r_q) : 15'(r_q);
	assign in_band = ({1'b0, r_abs} < {2'b00, dead_band_q});

	// |error - previous error| * 1000, sign kept aside
	assign rd_diff = {{2{r_q[14]}}, r_q} - {prev_error_q[15], prev_error_q};
	assign rd_abs  = rd_diff[16] ? 16'(-rd_diff) : 16'(rd_diff);
	assign dd_next = {rd_abs, 10'd0} - {6'd0, rd_abs, 4'd0} - {7'd0, rd_abs, 3'd0};

	// integral update with saturation to 32 bits
	assign ed_mag = {1'b0, mul_product};
	assign ed     = r_q[14] ? -ed_mag : ed_mag;
	assign s_sum  = {{17{integral_q[31]}}, integral_q} + ed;
	assign s_fits = (&s_sum[48:31]) || !(|s_sum[48:31]);
	assign s_sat  = s_fits ? s_sum[31:0] : (s_sum[48] ? 32'sh8000_0000 : 32'sh7fff_ffff);
	assign s_abs  = s_q[31] ? 32'(-s_q) : 32'(s_q);

	assign i_mag = {1'b0, div_quotient[37:0]};
	assign d_mag = {1'b0, div_quotient[41:0]};
	assign p_mag = {1'b0, mul_product[29:0]};

	// truncate toward zero, then clamp to the turn limit
	assign w_bias   = sum_q[SUM_W-1] ? SUM_W'((64'd1 << AFB) - 64'd1) : '0;
	assign w_biased = sum_q + w_bias;
	assign lim_pos  = {{(W_W-14){1'b0}}, turn_limit_q};
	always_comb begin
		if (w_q > lim_pos) begin
			w_lim = lim_pos;
		end else if (w_q < -lim_pos) begin
			w_lim = -lim_pos;
		end else begin
			w_lim = w_q;
		end
	end

	// operand selection for the shared units
	always_comb begin
		case (state_q)
			ST_MUL_E: begin
				mul_a = {1'b0, r_abs};
				mul_b = dt_q;
			end
			ST_MUL_I: begin
				mul_a = gain_integ_q;
				mul_b = s_abs;
			end
			ST_MUL_D: begin
				mul_a = gain_deriv_q;
				mul_b = {6'd0, dd_q};
			end
			default: begin
				mul_a = gain_prop_q;
				mul_b = {17'd0, r_abs};
			end
		endcase
	end

	assign div_divisor = (state_q == ST_DIV_D) ? dt_q : 32'(hps_pkg::INTEG_SCALE);

	hps_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start_q),
		.mult_a  (mul_a),
		.mult_b  (mul_b),
		.stat    (mul_stat),
		.product (mul_product)
	);

	hps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (mul_product),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.quotient (div_quotient)
	);

	// sequencer, configuration, controller state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			mul_start_q     <= 1'b0;
			div_start_q     <= 1'b0;
			goal_heading_q  <= 15'd0;
			gain_prop_q     <= 16'd6144;
			gain_integ_q    <= 16'd41;
			gain_deriv_q    <= 16'd2048;
			turn_limit_q    <= 14'd2458;
			dead_band_q     <= 14'd410;
			cruise_speed_q  <= 16'd200;
			update_period_q <= 16'd1000;
			last_update_q   <= '0;
			integral_q      <= '0;
			prev_error_q    <= '0;
			m_tvalid_q      <= 1'b0;
			out_speed_q     <= '0;
			out_turn_q      <= '0;
			out_stop_q      <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;

			if (cfg_wr_en) begin
				case (hps_pkg::reg_index_t'(cfg_wr_index))
					hps_pkg::REG_GOAL_HEADING:  goal_heading_q  <= cfg_wr_data[14:0];
					hps_pkg::REG_GAIN_PROP:     gain_prop_q     <= cfg_wr_data;
					hps_pkg::REG_GAIN_INTEG:    gain_integ_q    <= cfg_wr_data;
					hps_pkg::REG_GAIN_DERIV:    gain_deriv_q    <= cfg_wr_data;
					hps_pkg::REG_TURN_LIMIT:    turn_limit_q    <= cfg_wr_data[13:0];
					hps_pkg::REG_DEAD_BAND:     dead_band_q     <= cfg_wr_data[13:0];
					hps_pkg::REG_CRUISE_SPEED:  cruise_speed_q  <= cfg_wr_data;
					hps_pkg::REG_UPDATE_PERIOD: update_period_q <= cfg_wr_data;
					default: ;
				endcase
			end

			// drop valid once taken, unless a new result loads in the same cycle
			if (m_tvalid_q && m_tready && state_q != ST_EMIT) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (too_early) begin
						state_q <= ST_IDLE;
					end else begin
						last_update_q <= now_q;
						state_q       <= ST_BAND;
					end
				end
				ST_BAND: begin
					if (in_band) begin
						state_q <= ST_EMIT;
					end else begin
						mul_start_q <= 1'b1;
						state_q     <= ST_MUL_E;
					end
				end
				ST_MUL_E: begin
					if (mul_stat.done) begin
						state_q <= ST_SUM_S;
					end
				end
				ST_SUM_S: begin
					mul_start_q <= 1'b1;
					state_q     <= ST_MUL_I;
				end
				ST_MUL_I: begin
					if (mul_stat.done) begin
						div_start_q <= 1'b1;
						state_q     <= ST_DIV_I;
					end
				end
				ST_DIV_I: begin
					if (div_stat.done) begin
						mul_start_q <= 1'b1;
						state_q     <= ST_MUL_D;
					end
				end
				ST_MUL_D: begin
					if (mul_stat.done) begin
						div_start_q <= 1'b1;
						state_q     <= ST_DIV_D;
					end
				end
				ST_DIV_D: begin
					if (div_stat.done) begin
						mul_start_q <= 1'b1;
						state_q     <= ST_MUL_P;
					end
				end
				ST_MUL_P: begin
					if (mul_stat.done) begin
						state_q <= ST_SUM_W;
					end
				end
				ST_SUM_W: begin
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					state_q <= ST_LIMIT;
				end
				ST_LIMIT: begin
					integral_q   <= s_q;
					prev_error_q <= {r_q[14], r_q};
					state_q      <= ST_EMIT;
				end
				ST_EMIT: begin
					// hold the result until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q  <= 1'b1;
						out_speed_q <= res_speed_q;
						out_turn_q  <= res_turn_q;
						out_stop_q  <= res_stop_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					now_q  <= s_tdata[31:0];
					dt_q   <= s_tdata[31:0] - last_update_q;
					diff_q <= {{2{goal_heading_q[14]}}, goal_heading_q}
						- {{2{s_tdata[46]}}, s_tdata[46:32]};
				end
			end
			ST_CHECK: begin
				r_q <= m4[14:0];
			end
			ST_BAND: begin
				res_speed_q <= '0;
				res_turn_q  <= '0;
				res_stop_q  <= 1'b1;
				dd_q        <= dd_next;
				dd_neg_q    <= rd_diff[16];
			end
			ST_SUM_S: begin
				s_q <= s_sat;
			end
			ST_DIV_I: begin
				if (div_stat.done) begin
					i_q <= s_q[31] ? -i_mag : i_mag;
				end
			end
			ST_DIV_D: begin
				if (div_stat.done) begin
					d_q <= dd_neg_q ? -d_mag : d_mag;
				end
			end
			ST_MUL_P: begin
				if (mul_stat.done) begin
					p_q <= r_q[14] ? -p_mag : p_mag;
				end
			end
			ST_SUM_W: begin
				sum_q <= {{(SUM_W-31){p_q[30]}}, p_q}
					+ {{(SUM_W-39){i_q[38]}}, i_q}
					+ {{(SUM_W-43){d_q[42]}}, d_q};
			end
			ST_CLAMP: begin
				w_q <= w_biased[SUM_W-1:AFB];
			end
			ST_LIMIT: begin
				res_speed_q <= cruise_speed_q;
				res_turn_q  <= w_lim[14:0];
				res_stop_q  <= 1'b0;
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, out_turn_q, out_speed_q};
	assign m_tuser  = out_stop_q;

	assign mul_phase  = state_q inside {ST_MUL_E, ST_MUL_I, ST_MUL_D, ST_MUL_P};
	assign units_busy = mul_stat.busy || div_stat.busy;

	`ASSERT_NEVER(a_units_overlap, clk, arst_n, mul_stat.busy && div_stat.busy)
	`ASSERT_IMPLY(a_accept_units_free, clk, arst_n, s_tvalid && s_tready, !units_busy)
	`ASSERT_IMPLY(a_stop_is_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == 32'd0)
	`ASSERT_IMPLY(a_mul_done_owned, clk, arst_n, mul_stat.done, mul_phase)

endmodule
